### rtl/cfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfla_pkg: shared types and constants of the chunked free-list allocator
// Transaction payload structs, result status codes, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cfla_pkg;

    localparam int CHUNK_SIZE_DEF = 24;
    localparam int NUM_CHUNKS_DEF = 16;

    localparam int SLOT_FIELD_W = 9;

    // Request type codes.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_REL     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_OOM     = 2'd3
    } t_status;

    typedef struct packed {
        logic                    req_type;
        logic [SLOT_FIELD_W-1:0] release_slot;
        logic                    release_is_null;
    } t_req;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] granted_slot;
        t_status                 status;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;       // capture the incoming request
        logic    push;        // release: link slot in front of the head
        logic    pop;         // allocate: take the head slot
        logic    fill_start;  // begin linking the next unused chunk
        logic    fill_step;   // write one link of the chunk being linked
        logic    emit;        // register a result for the output
        t_status status;      // status code of that result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_release;    // latched request is a release
        logic rel_ok;         // latched release is non-null and in range
        logic head_empty;     // free list is empty
        logic chunks_full;    // every chunk has been linked
        logic fill_last;      // current fill write is the chunk's last link
    } t_flags;

endpackage

### rtl/cfla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfla_ctrl: allocator controller
// Sequences each request: capture, then a single execute step, or a chunk
// fill of one link write per cycle ending in the allocation.
// ----------------------------------------------------------------------------
module cfla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cfla_pkg::t_flags i_flags,
    output cfla_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = cfla_pkg::ST_ALLOC;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (i_flags.req_release) begin
                    o_cmd.emit = 1'b1;
                    if (i_flags.rel_ok) begin
                        o_cmd.push   = 1'b1;
                        o_cmd.status = cfla_pkg::ST_REL;
                    end else begin
                        o_cmd.status = cfla_pkg::ST_IGNORED;
                    end
                end else if (!i_flags.head_empty) begin
                    o_cmd.pop    = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = cfla_pkg::ST_ALLOC;
                end else if (i_flags.chunks_full) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = cfla_pkg::ST_OOM;
                end else begin
                    o_cmd.fill_start = 1'b1;
                    n_state          = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_flags.fill_last) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = cfla_pkg::ST_ALLOC;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/cfla_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfla_dpath: allocator datapath
// Link memory, free-list head, chunk bookkeeping, fill counter and the
// registered result.
// ----------------------------------------------------------------------------
module cfla_dpath #(
    parameter int CHUNK_SIZE = cfla_pkg::CHUNK_SIZE_DEF,
    parameter int NUM_CHUNKS = cfla_pkg::NUM_CHUNKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfla_pkg::t_req   i_req,
    input  cfla_pkg::t_cmd   i_cmd,
    output cfla_pkg::t_flags o_flags,
    output cfla_pkg::t_res   o_res,
    output logic             o_res_valid
);

    localparam int NUM_SLOTS = CHUNK_SIZE * NUM_CHUNKS;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LINK_W    = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W     = $clog2(NUM_CHUNKS + 1);
    localparam int FILL_W    = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;

    // Links are coded as slot index plus one; zero ends the list.
    logic [LINK_W-1:0] r_link_mem [NUM_SLOTS];
    logic [LINK_W-1:0] r_rd_data;

    cfla_pkg::t_req    r_req;
    logic [LINK_W-1:0] r_head;
    logic [CNT_W-1:0]  r_chunks;
    logic [LINK_W-1:0] r_base;
    logic [SLOT_W-1:0] r_fill_ptr;
    logic [FILL_W-1:0] r_fill_cnt;
    cfla_pkg::t_res    r_res;
    logic              r_res_valid;

    logic [LINK_W-1:0] head_m1;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              fill_last;
    logic              rel_ok;
    logic              fill_done;

    assign head_m1   = r_head - LINK_W'(1);
    assign rd_addr   = (r_head == '0) ? '0 : head_m1[SLOT_W-1:0];
    assign fill_last = (r_fill_cnt == FILL_W'(CHUNK_SIZE - 1));
    assign fill_done = i_cmd.fill_step && fill_last;
    assign rel_ok    = !r_req.release_is_null &&
                       (32'(r_req.release_slot) < 32'(NUM_SLOTS));

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_fill_ptr;
        wr_data = fill_last ? '0 : (LINK_W'(r_fill_ptr) + LINK_W'(2));
        if (i_cmd.push) begin
            mem_we  = 1'b1;
            wr_addr = SLOT_W'(r_req.release_slot);
            wr_data = r_head;
        end else if (i_cmd.fill_step) begin
            mem_we = 1'b1;
        end
    end

    // Link memory: one write and one registered read per cycle. The read
    // always follows the current head so its successor is ready at execute.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_link_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.fill_start) begin
            r_fill_ptr <= r_base[SLOT_W-1:0];
            r_fill_cnt <= '0;
        end else if (i_cmd.fill_step) begin
            r_fill_ptr <= r_fill_ptr + SLOT_W'(1);
            r_fill_cnt <= r_fill_cnt + FILL_W'(1);
        end
        r_res.status <= i_cmd.status;
        if (i_cmd.pop) begin
            r_res.granted_slot <= cfla_pkg::SLOT_FIELD_W'(head_m1);
        end else if (fill_done) begin
            r_res.granted_slot <= cfla_pkg::SLOT_FIELD_W'(r_base);
        end else begin
            r_res.granted_slot <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_chunks    <= '0;
            r_base      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.emit;
            if (i_cmd.push) begin
                r_head <= LINK_W'(r_req.release_slot) + LINK_W'(1);
            end else if (i_cmd.pop) begin
                r_head <= r_rd_data;
            end else if (fill_done) begin
                // The first slot of the new chunk is handed out at once, so
                // the head moves straight to its successor.
                r_head   <= (CHUNK_SIZE > 1) ? (r_base + LINK_W'(2)) : '0;
                r_chunks <= r_chunks + CNT_W'(1);
                r_base   <= r_base + LINK_W'(CHUNK_SIZE);
            end
        end
    end

    assign o_flags.req_release = (r_req.req_type == cfla_pkg::REQ_RELEASE);
    assign o_flags.rel_ok      = rel_ok;
    assign o_flags.head_empty  = (r_head == '0);
    assign o_flags.chunks_full = (r_chunks == CNT_W'(NUM_CHUNKS));
    assign o_flags.fill_last   = fill_last;

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

### rtl/chunked_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_free_list_allocator_core: fixed-slot free-list allocator
// Hands out and takes back slots kept on a linked free list in a link
// memory, linking fresh chunks of CHUNK_SIZE slots on demand.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken on a rising edge with start high and busy
//   low; i_req carries the request type, the slot released and its null flag.
//   Every request yields exactly one result transaction: o_res is valid for
//   one cycle while o_res_valid is high. The receiver cannot stall, so the
//   result must be taken in that cycle.
//   For a release, an allocation from a non-empty list, or an out-of-memory
//   answer, the request is captured, executed in a single step, and the
//   result is registered onto the ports. A new request is not taken until
//   the previous one has executed and busy is low again.
//   An allocation that finds the list empty links the next unused chunk, one
//   link memory write per cycle, until all CHUNK_SIZE links are written; this
//   happens once per chunk, at most NUM_CHUNKS times. The single write port
//   of the link memory is why the links are written one at a time.
//   Reset empties the free list and marks every chunk unused; the link
//   memory is not cleared, as every link is written before it is followed.
//   Slot indices on the ports are nine bits wide.
// ----------------------------------------------------------------------------
module chunked_free_list_allocator_core #(
    parameter int CHUNK_SIZE = cfla_pkg::CHUNK_SIZE_DEF,
    parameter int NUM_CHUNKS = cfla_pkg::NUM_CHUNKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  cfla_pkg::t_req i_req,
    output cfla_pkg::t_res o_res,
    output logic           o_res_valid
);

    // Command and status bundles between controller and datapath.
    cfla_pkg::t_cmd   cmd;
    cfla_pkg::t_flags flags;

    // The controller steps each request through capture, execute and, when
    // needed, the chunk fill.
    cfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_flags (flags),
        .o_cmd   (cmd)
    );

    // The datapath holds the link memory, the list head, the chunk count and
    // the result register.
    cfla_dpath #(
        .CHUNK_SIZE (CHUNK_SIZE),
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

endmodule
